// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the segment writer checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// ----- rtl/dlsw_pkg.sv -----
// ----------------------------------------------------------------------------
// dlsw_pkg
// Types, constants and the segment table of the decimal segment writer.
// ----------------------------------------------------------------------------
package dlsw_pkg;

    localparam int NUM_DIGITS   = 6;
    localparam int SEGMENT_ROWS = 4;
    localparam int ROW_STRIDE   = 5;

    localparam int VALUE_W = 32;
    localparam int OFF_W   = 5;
    localparam int DATA_W  = 8;
    localparam int DIGIT_W = 4;
    localparam int WORD_W  = DIGIT_W * SEGMENT_ROWS;

    localparam int POS_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam int ROW_W = (SEGMENT_ROWS > 1) ? $clog2(SEGMENT_ROWS) : 1;

    localparam int MAX_OFFSET = (NUM_DIGITS - 1) / 2 + ROW_STRIDE * (SEGMENT_ROWS - 1);
    localparam int MEM_DEPTH  = MAX_OFFSET + 1;
    localparam int MEM_AW     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    // divide by ten: q = (v * 0xCCCCCCCD) >> 35, exact for v < 2^32
    localparam logic [VALUE_W-1:0] DIV10_RECIP = 32'hCCCC_CCCD;
    localparam int                 DIV10_SHIFT = 35;

    localparam logic [15:0] SEG_0 = 16'h1551;
    localparam logic [15:0] SEG_1 = 16'h0110;
    localparam logic [15:0] SEG_2 = 16'h1E11;
    localparam logic [15:0] SEG_3 = 16'h1B11;
    localparam logic [15:0] SEG_4 = 16'h0B50;
    localparam logic [15:0] SEG_5 = 16'h1B41;
    localparam logic [15:0] SEG_6 = 16'h1F41;
    localparam logic [15:0] SEG_7 = 16'h0111;
    localparam logic [15:0] SEG_8 = 16'h1F51;
    localparam logic [15:0] SEG_9 = 16'h0B51;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_DIV,
        FR_PUSH
    } front_state_t;

    typedef struct packed {
        logic [POS_W-1:0]   pos;
        logic [DIGIT_W-1:0] digit;
        logic               last;
    } digit_entry_t;

    function automatic logic [WORD_W-1:0] seg_word(input logic [DIGIT_W-1:0] d);
        logic [15:0] w;
        unique case (d)
            4'd0:    w = SEG_0;
            4'd1:    w = SEG_1;
            4'd2:    w = SEG_2;
            4'd3:    w = SEG_3;
            4'd4:    w = SEG_4;
            4'd5:    w = SEG_5;
            4'd6:    w = SEG_6;
            4'd7:    w = SEG_7;
            4'd8:    w = SEG_8;
            4'd9:    w = SEG_9;
            default: w = '0;
        endcase
        return w[WORD_W-1:0];
    endfunction

endpackage

// ----- rtl/dlsw_fifo.sv -----
// ----------------------------------------------------------------------------
// dlsw_fifo
// Short digit queue between the divider front and the segment writer back.
// ----------------------------------------------------------------------------
module dlsw_fifo
    import dlsw_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    output logic         push_ready,
    input  digit_entry_t push_entry,
    output logic         pop_valid,
    input  logic         pop_ready,
    output digit_entry_t pop_entry
);

    digit_entry_t          entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic                  do_push;
    logic                  do_pop;

    assign push_ready = (count_reg != FIFO_CNT_W'(FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ----- rtl/dlsw_front.sv -----
// ----------------------------------------------------------------------------
// dlsw_front
// Accepts values, drops non-positive ones and splits the rest into digits,
// one reciprocal division by ten per digit, least significant first.
// ----------------------------------------------------------------------------
module dlsw_front
    import dlsw_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [VALUE_W-1:0] value,
    output logic                      push_valid,
    input  logic                      push_ready,
    output digit_entry_t              push_entry
);

    front_state_t       state_reg, state_next;
    logic [VALUE_W-1:0] v_reg, v_next;
    logic [VALUE_W-1:0] q_reg, q_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [2*VALUE_W-1:0] prod;
    logic [VALUE_W-1:0] q_calc;
    logic [VALUE_W-1:0] rem;
    logic               digit_last;

    assign prod       = (2*VALUE_W)'(v_reg) * (2*VALUE_W)'(DIV10_RECIP);
    assign q_calc     = VALUE_W'(prod >> DIV10_SHIFT);
    assign rem        = v_reg - ((q_reg << 3) + (q_reg << 1));
    assign digit_last = (pos_reg == '0) || (q_reg == '0);

    always_comb
    begin
        state_next       = state_reg;
        v_next           = v_reg;
        q_next           = q_reg;
        pos_next         = pos_reg;
        in_ready         = 1'b0;
        push_valid       = 1'b0;
        push_entry.pos   = pos_reg;
        push_entry.digit = rem[DIGIT_W-1:0];
        push_entry.last  = digit_last;
        unique case (state_reg)
            FR_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && (value > 0))
                begin
                    v_next     = unsigned'(value);
                    pos_next   = POS_W'(NUM_DIGITS - 1);
                    state_next = FR_DIV;
                end
            end
            FR_DIV:
            begin
                q_next     = q_calc;
                state_next = FR_PUSH;
            end
            FR_PUSH:
            begin
                push_valid = 1'b1;
                if (push_ready)
                begin
                    if (digit_last)
                    begin
                        state_next = FR_IDLE;
                    end
                    else
                    begin
                        v_next     = q_reg;
                        pos_next   = pos_reg - 1'b1;
                        state_next = FR_DIV;
                    end
                end
            end
            default:
            begin
                state_next = FR_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FR_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        q_reg   <= q_next;
        pos_reg <= pos_next;
    end

endmodule

// ----- rtl/dlsw_back.sv -----
// ----------------------------------------------------------------------------
// dlsw_back
// Segment writer: one byte read-modify-write per cycle unless output stalls,
// over each digit's rows; a read stage feeds the merge into a result register.
// ----------------------------------------------------------------------------
module dlsw_back
    import dlsw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  digit_entry_t      pop_entry,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [OFF_W-1:0]  reg_offset,
    output logic [DATA_W-1:0] reg_data,
    output logic              last
);

    logic [DATA_W-1:0]  mem_reg [MEM_DEPTH];

    logic [ROW_W-1:0]   row_reg;
    logic               s1_valid_reg;
    logic [OFF_W-1:0]   s1_off_reg;
    logic [DIGIT_W-1:0] s1_nib_reg;
    logic               s1_odd_reg;
    logic               s1_last_reg;
    logic [DATA_W-1:0]  rd_data_reg;

    logic               out_valid_reg;
    logic [OFF_W-1:0]   out_off_reg;
    logic [DATA_W-1:0]  out_data_reg;
    logic               out_last_reg;

    logic [WORD_W-1:0]  word;
    logic [OFF_W-1:0]   rd_off;
    logic               row_end;
    logic               r_fire;
    logic               w_fire;
    logic [DATA_W-1:0]  merged;

    assign word    = seg_word(pop_entry.digit);
    assign rd_off  = OFF_W'(pop_entry.pos >> 1) + OFF_W'(row_reg) * OFF_W'(ROW_STRIDE);
    assign row_end = (row_reg == ROW_W'(SEGMENT_ROWS - 1));
    assign w_fire  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign r_fire  = pop_valid && (!s1_valid_reg || w_fire);
    assign pop_ready = r_fire && row_end;
    assign merged  = s1_odd_reg ? {s1_nib_reg, rd_data_reg[3:0]}
                                : {rd_data_reg[7:4], s1_nib_reg};

    assign out_valid  = out_valid_reg;
    assign reg_offset = out_off_reg;
    assign reg_data   = out_data_reg;
    assign last       = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (r_fire)
            begin
                row_reg <= row_end ? '0 : row_reg + 1'b1;
            end
            if (r_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (w_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (w_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // segment memory; a read of the byte being written this cycle takes the new value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MEM_DEPTH; i++)
            begin
                mem_reg[i] <= '0;
            end
        end
        else if (w_fire)
        begin
            mem_reg[s1_off_reg[MEM_AW-1:0]] <= merged;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r_fire)
        begin
            s1_off_reg  <= rd_off;
            s1_nib_reg  <= word[row_reg*DIGIT_W +: DIGIT_W];
            s1_odd_reg  <= pop_entry.pos[0];
            s1_last_reg <= pop_entry.last && row_end;
            if (w_fire && (s1_off_reg == rd_off))
            begin
                rd_data_reg <= merged;
            end
            else
            begin
                rd_data_reg <= mem_reg[rd_off[MEM_AW-1:0]];
            end
        end
        if (w_fire)
        begin
            out_off_reg  <= s1_off_reg;
            out_data_reg <= merged;
            out_last_reg <= s1_last_reg;
        end
    end

endmodule

// ----- rtl/decimal_to_lcd_segment_writer.sv -----
// ----------------------------------------------------------------------------
// decimal_to_lcd_segment_writer
// A positive value is split into at most six decimal digits and every digit
// is merged nibble-wise into four bytes of segment memory; each byte write
// comes out as one result beat, the final one marked by last. Zero and
// negative values are accepted and give no beats. The front divider works
// on one digit at a time, a division then a push, and hands digits to the
// back through a four-entry queue; it takes no new value until the last digit
// of the current one is pushed, and stalls on the result side back up the
// queue and hold the front for as long as they last. The back writes one
// byte per cycle while the result side takes every beat, so a value with d
// digits yields 4*d beats, at most 24; that single byte port of the segment
// memory sets the sustained rate.
// ----------------------------------------------------------------------------
module decimal_to_lcd_segment_writer
    import dlsw_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [VALUE_W-1:0] value,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [OFF_W-1:0]          reg_offset,
    output logic [DATA_W-1:0]         reg_data,
    output logic                      last
);

    logic         push_valid;
    logic         push_ready;
    digit_entry_t push_entry;
    logic         pop_valid;
    logic         pop_ready;
    digit_entry_t pop_entry;

    dlsw_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value      (value),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    dlsw_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    dlsw_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .reg_offset (reg_offset),
        .reg_data   (reg_data),
        .last       (last)
    );

endmodule

// ----- rtl/dlsw_checker.sv -----
// ----------------------------------------------------------------------------
// dlsw_checker
// Port-level checks of the segment writer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dlsw_checker
    import dlsw_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic signed [VALUE_W-1:0] value,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [OFF_W-1:0]          reg_offset,
    input logic [DATA_W-1:0]         reg_data,
    input logic                      last
);

    `ASSERT_PROP(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(reg_offset) && $stable(reg_data) && $stable(last), "result beat changed while stalled")
    `ASSERT_NEVER(a_off_range, clk, rst_n, out_valid && (reg_offset > OFF_W'(MAX_OFFSET)), "offset beyond segment memory")
    `ASSERT_PROP(a_busy_after_value, clk, rst_n, in_valid && in_ready && (value > 0) |=> !in_ready, "positive value did not occupy the front")

endmodule

bind decimal_to_lcd_segment_writer dlsw_checker u_dlsw_checker (.*);
